// ===== rtl/fpd_pkg.sv =====
// Shared types, constants and register codes for the Fourier PSF deconvolution pipeline.
package fpd_pkg;

    localparam int MAX_ROWS = 1024;
    localparam int QBITS    = 32;
    localparam int ADDR_W   = 6;
    localparam int DATA_W   = 64;

    localparam logic [2:0] REG_GRID_ROWS = 3'd0;
    localparam logic [2:0] REG_KX_STEP   = 3'd1;
    localparam logic [2:0] REG_KY_STEP   = 3'd2;
    localparam logic [2:0] REG_CUTOFF    = 3'd3;
    localparam logic [2:0] REG_FLOOR     = 3'd4;

    localparam logic [10:0] GRID_ROWS_RST = 11'd64;
    localparam logic [31:0] STEP_RST      = 32'h0100_0000;
    localparam logic [39:0] CUTOFF_RST    = 40'hFF_FFFF_FFFF;
    localparam logic [30:0] FLOOR_RST     = 31'h0001_0000;

    typedef enum logic [1:0] {
        OUT_ZERO  = 2'd0,
        OUT_FLOOR = 2'd1,
        OUT_PSF   = 2'd2
    } outcome_t;

    typedef struct packed {
        logic [10:0] grid_rows;
        logic [31:0] kx_step;
        logic [31:0] ky_step;
        logic [39:0] cutoff_squared;
        logic [30:0] floor_value;
    } cfg_t;

    typedef struct packed {
        logic [9:0]         row_index;
        logic [9:0]         col_index;
        logic signed [31:0] data_real;
        logic signed [31:0] data_imag;
        logic signed [31:0] psf_real;
        logic signed [31:0] psf_imag;
    } pix_t;

    typedef struct packed {
        logic       beyond;
        outcome_t   outcome;
        logic [79:0] n_re;
        logic [79:0] n_im;
        logic       neg_re;
        logic       neg_im;
        logic [63:0] d;
    } div_in_t;

    typedef struct packed {
        logic signed [31:0] out_real;
        logic signed [31:0] out_imag;
        outcome_t           outcome;
        logic               saturated;
    } res_t;

endpackage

// ===== rtl/fpd_if.sv =====
// Valid/ready channel interfaces for pixel requests and results.
interface fpd_pixel_if;
    logic               valid;
    logic               ready;
    logic [9:0]         row_index;
    logic [9:0]         col_index;
    logic signed [31:0] data_real;
    logic signed [31:0] data_imag;
    logic signed [31:0] psf_real;
    logic signed [31:0] psf_imag;

    modport source (output valid, row_index, col_index, data_real, data_imag, psf_real,
                    psf_imag, input ready);
    modport sink (input valid, row_index, col_index, data_real, data_imag, psf_real,
                  psf_imag, output ready);
endinterface

interface fpd_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_real;
    logic signed [31:0] out_imag;
    logic [1:0]         outcome;
    logic               saturated;

    modport source (output valid, out_real, out_imag, outcome, saturated, input ready);
    modport sink (input valid, out_real, out_imag, outcome, saturated, output ready);
endinterface

// ===== rtl/fourier_psf_deconvolve_pixel.sv =====
// Top level: APB register file and the deconvolution pipeline between the pixel and result channels.
// Takes one half-plane Fourier pixel per clock unless a stall reaches the input; deconvolved values
// come back one per pixel, in order, through 4 front stages (frequency radius, |psf|^2, operand
// select), a 32-stage restoring divider that yields one quotient bit per stage plus its load
// stage, and the clip/output register. A held result stalls only as far back as the first empty
// stage. Registers sit at byte address 8*i on a 64-bit APB port and may be written only while no
// request is in flight.
module fourier_psf_deconvolve_pixel (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fpd_pkg::ADDR_W-1:0]    paddr,
    input  logic [fpd_pkg::DATA_W-1:0]    pwdata,
    output logic [fpd_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    fpd_pixel_if.sink                     pixel,
    fpd_result_if.source                  result
);

    fpd_pkg::cfg_t    cfg_reg, cfg_next;
    fpd_pkg::pix_t    pix;
    fpd_pkg::div_in_t fdata;
    fpd_pkg::res_t    res;
    logic             f_valid;
    logic             d_ready;
    logic             wr;
    logic [2:0]       idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign idx    = paddr[5:3];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (idx)
                fpd_pkg::REG_GRID_ROWS:
                begin
                    cfg_next.grid_rows = (pwdata[10:0] > 11'(fpd_pkg::MAX_ROWS))
                                       ? 11'(fpd_pkg::MAX_ROWS) : pwdata[10:0];
                end
                fpd_pkg::REG_KX_STEP: cfg_next.kx_step        = pwdata[31:0];
                fpd_pkg::REG_KY_STEP: cfg_next.ky_step        = pwdata[31:0];
                fpd_pkg::REG_CUTOFF:  cfg_next.cutoff_squared = pwdata[39:0];
                fpd_pkg::REG_FLOOR:   cfg_next.floor_value    = pwdata[30:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_rows      <= fpd_pkg::GRID_ROWS_RST;
            cfg_reg.kx_step        <= fpd_pkg::STEP_RST;
            cfg_reg.ky_step        <= fpd_pkg::STEP_RST;
            cfg_reg.cutoff_squared <= fpd_pkg::CUTOFF_RST;
            cfg_reg.floor_value    <= fpd_pkg::FLOOR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            fpd_pkg::REG_GRID_ROWS: prdata = 64'(cfg_reg.grid_rows);
            fpd_pkg::REG_KX_STEP:   prdata = 64'(cfg_reg.kx_step);
            fpd_pkg::REG_KY_STEP:   prdata = 64'(cfg_reg.ky_step);
            fpd_pkg::REG_CUTOFF:    prdata = 64'(cfg_reg.cutoff_squared);
            fpd_pkg::REG_FLOOR:     prdata = 64'(cfg_reg.floor_value);
            default:                prdata = '0;
        endcase
    end

    always_comb
    begin
        pix.row_index = pixel.row_index;
        pix.col_index = pixel.col_index;
        pix.data_real = pixel.data_real;
        pix.data_imag = pixel.data_imag;
        pix.psf_real  = pixel.psf_real;
        pix.psf_imag  = pixel.psf_imag;
    end

    fpd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (pixel.valid),
        .in_ready  (pixel.ready),
        .pix       (pix),
        .out_valid (f_valid),
        .out_ready (d_ready),
        .dout      (fdata)
    );

    fpd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (d_ready),
        .din       (fdata),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .dout      (res)
    );

    assign result.out_real  = res.out_real;
    assign result.out_imag  = res.out_imag;
    assign result.outcome   = 2'(res.outcome);
    assign result.saturated = res.saturated;

endmodule

// ===== rtl/fpd_front.sv =====
// Front pipeline: frequency radius, cutoff test, PSF magnitude and divider operand select.
module fpd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  fpd_pkg::cfg_t    cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  fpd_pkg::pix_t    pix,
    output logic             out_valid,
    input  logic             out_ready,
    output fpd_pkg::div_in_t dout
);

    typedef struct packed {
        logic [41:0]        kx;
        logic [42:0]        ky;
        logic signed [63:0] prr;
        logic signed [63:0] pii;
        logic signed [63:0] pir;
        logic signed [63:0] pri;
        logic signed [63:0] ppr;
        logic signed [63:0] ppi;
        logic [61:0]        fl2;
        logic signed [31:0] dr;
        logic signed [31:0] di;
    } s1_t;

    typedef struct packed {
        logic [63:0]        xll;
        logic [41:0]        xhl;
        logic [19:0]        xhh;
        logic [63:0]        yll;
        logic [42:0]        yhl;
        logic [21:0]        yhh;
        logic [63:0]        pmag;
        logic signed [64:0] sr;
        logic signed [64:0] si;
        logic               below;
        logic [31:0]        amr;
        logic [31:0]        ami;
        logic               dnr;
        logic               dni;
    } s2_t;

    typedef struct packed {
        logic [83:0] kx2;
        logic [85:0] ky2;
        logic [63:0] pmag;
        logic        below;
        logic [31:0] amr;
        logic [31:0] ami;
        logic        dnr;
        logic        dni;
        logic [63:0] mr;
        logic [63:0] mi;
        logic        snr;
        logic        sni;
    } s3_t;

    localparam int NST = 4;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] v_next;
    logic [NST-1:0] en;

    s1_t              s1_reg, s1_next;
    s2_t              s2_reg, s2_next;
    s3_t              s3_reg, s3_next;
    fpd_pkg::div_in_t s4_reg, s4_next;

    logic signed [11:0] kdiff;
    logic [10:0]        kymag;
    logic [86:0]        rsq;

    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || out_ready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next[0] = en[0] ? in_valid : v_reg[0];
        for (int i = 1; i < NST; i++)
        begin
            v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // Stage 1: signed row frequency, step products, complex products
    always_comb
    begin
        kdiff = $signed({2'b00, pix.row_index}) - $signed({1'b0, cfg.grid_rows});
        if ({1'b0, pix.row_index} < {1'b0, cfg.grid_rows[10:1]})
        begin
            kymag = {1'b0, pix.row_index};
        end
        else if (kdiff[11])
        begin
            kymag = 11'(-kdiff);
        end
        else
        begin
            kymag = kdiff[10:0];
        end
        s1_next.kx  = pix.col_index * cfg.kx_step;
        s1_next.ky  = kymag * cfg.ky_step;
        s1_next.prr = pix.data_real * pix.psf_real;
        s1_next.pii = pix.data_imag * pix.psf_imag;
        s1_next.pir = pix.data_imag * pix.psf_real;
        s1_next.pri = pix.data_real * pix.psf_imag;
        s1_next.ppr = pix.psf_real * pix.psf_real;
        s1_next.ppi = pix.psf_imag * pix.psf_imag;
        s1_next.fl2 = cfg.floor_value * cfg.floor_value;
        s1_next.dr  = pix.data_real;
        s1_next.di  = pix.data_imag;
    end

    // Stage 2: partial squares, |psf|^2, numerator sums, floor test
    always_comb
    begin
        s2_next.xll   = s1_reg.kx[31:0] * s1_reg.kx[31:0];
        s2_next.xhl   = s1_reg.kx[41:32] * s1_reg.kx[31:0];
        s2_next.xhh   = s1_reg.kx[41:32] * s1_reg.kx[41:32];
        s2_next.yll   = s1_reg.ky[31:0] * s1_reg.ky[31:0];
        s2_next.yhl   = s1_reg.ky[42:32] * s1_reg.ky[31:0];
        s2_next.yhh   = s1_reg.ky[42:32] * s1_reg.ky[42:32];
        s2_next.pmag  = 64'(s1_reg.ppr) + 64'(s1_reg.ppi);
        s2_next.sr    = 65'(s1_reg.prr) + 65'(s1_reg.pii);
        s2_next.si    = 65'(s1_reg.pir) - 65'(s1_reg.pri);
        s2_next.below = s2_next.pmag < {2'b00, s1_reg.fl2};
        s2_next.amr   = s1_reg.dr[31] ? 32'(-s1_reg.dr) : 32'(s1_reg.dr);
        s2_next.ami   = s1_reg.di[31] ? 32'(-s1_reg.di) : 32'(s1_reg.di);
        s2_next.dnr   = s1_reg.dr[31];
        s2_next.dni   = s1_reg.di[31];
    end

    // Stage 3: assemble squares, split numerators into sign and magnitude
    always_comb
    begin
        s3_next.kx2   = (84'(s2_reg.xhh) << 64) + (84'(s2_reg.xhl) << 33) + 84'(s2_reg.xll);
        s3_next.ky2   = (86'(s2_reg.yhh) << 64) + (86'(s2_reg.yhl) << 33) + 86'(s2_reg.yll);
        s3_next.pmag  = s2_reg.pmag;
        s3_next.below = s2_reg.below;
        s3_next.amr   = s2_reg.amr;
        s3_next.ami   = s2_reg.ami;
        s3_next.dnr   = s2_reg.dnr;
        s3_next.dni   = s2_reg.dni;
        s3_next.snr   = s2_reg.sr[64];
        s3_next.sni   = s2_reg.si[64];
        s3_next.mr    = s2_reg.sr[64] ? 64'(-s2_reg.sr) : s2_reg.sr[63:0];
        s3_next.mi    = s2_reg.si[64] ? 64'(-s2_reg.si) : s2_reg.si[63:0];
    end

    // Stage 4: cutoff compare and divider operands
    always_comb
    begin
        rsq            = 87'(s3_reg.kx2) + 87'(s3_reg.ky2);
        s4_next.beyond = rsq > {23'd0, cfg.cutoff_squared, 24'd0};
        if (s3_reg.below)
        begin
            s4_next.outcome = fpd_pkg::OUT_FLOOR;
            s4_next.n_re    = {32'd0, s3_reg.amr, 16'd0};
            s4_next.n_im    = {32'd0, s3_reg.ami, 16'd0};
            s4_next.neg_re  = s3_reg.dnr;
            s4_next.neg_im  = s3_reg.dni;
            s4_next.d       = {33'd0, cfg.floor_value};
        end
        else
        begin
            s4_next.outcome = fpd_pkg::OUT_PSF;
            s4_next.n_re    = {s3_reg.mr, 16'd0};
            s4_next.n_im    = {s3_reg.mi, 16'd0};
            s4_next.neg_re  = s3_reg.snr;
            s4_next.neg_im  = s3_reg.sni;
            s4_next.d       = s3_reg.pmag;
        end
        if (s4_next.beyond)
        begin
            s4_next.outcome = fpd_pkg::OUT_ZERO;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_reg <= s1_next;
        end
        if (en[1])
        begin
            s2_reg <= s2_next;
        end
        if (en[2])
        begin
            s3_reg <= s3_next;
        end
        if (en[3])
        begin
            s4_reg <= s4_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NST-1];
    assign dout      = s4_reg;

endmodule

// ===== rtl/fpd_div.sv =====
// Pipelined restoring divider for both quotient parts, with clipping and zero-divisor handling.
module fpd_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  fpd_pkg::div_in_t din,
    output logic             out_valid,
    input  logic             out_ready,
    output fpd_pkg::res_t    dout
);

    typedef struct packed {
        logic [63:0] rem;
        logic [31:0] nlo;
        logic [31:0] q;
        logic        ovf;
        logic        neg;
        logic        nz;
    } dlane_t;

    typedef struct packed {
        dlane_t              re;
        dlane_t              im;
        logic [63:0]         d;
        logic                beyond;
        fpd_pkg::outcome_t   outcome;
    } dstg_t;

    localparam int QB   = fpd_pkg::QBITS;
    localparam int LAST = QB + 1;

    function automatic dlane_t load_lane(logic [79:0] n, logic neg, logic [63:0] d);
        dlane_t l;
        l.rem = 64'(n[79:32]);
        l.nlo = n[31:0];
        l.q   = '0;
        l.ovf = 64'(n[79:32]) >= d;
        l.neg = neg;
        l.nz  = n != '0;
        return l;
    endfunction

    function automatic dlane_t step_lane(dlane_t l, logic [63:0] d);
        dlane_t      r;
        logic [64:0] rem2;
        logic        ge;
        rem2  = {l.rem, l.nlo[31]};
        ge    = rem2 >= {1'b0, d};
        r     = l;
        r.rem = ge ? 64'(rem2 - {1'b0, d}) : rem2[63:0];
        r.q   = {l.q[30:0], ge};
        r.nlo = {l.nlo[30:0], 1'b0};
        return r;
    endfunction

    // {saturated, value}
    function automatic logic [32:0] clip_lane(dlane_t l, logic dz);
        logic [32:0] r;
        if (dz)
        begin
            if (!l.nz)
            begin
                r = {1'b1, 32'd0};
            end
            else
            begin
                r = {1'b1, l.neg ? 32'h8000_0000 : 32'h7FFF_FFFF};
            end
        end
        else if (l.ovf)
        begin
            r = {1'b1, l.neg ? 32'h8000_0000 : 32'h7FFF_FFFF};
        end
        else if (!l.neg)
        begin
            r = (l.q > 32'h7FFF_FFFF) ? {1'b1, 32'h7FFF_FFFF} : {1'b0, l.q};
        end
        else
        begin
            r = (l.q > 32'h8000_0000) ? {1'b1, 32'h8000_0000} : {1'b0, 32'(-l.q)};
        end
        return r;
    endfunction

    logic [LAST:0] v_reg;
    logic [LAST:0] v_next;
    logic [LAST:0] en;

    dstg_t         stg_reg [0:QB];
    dstg_t         stg0_next;
    fpd_pkg::res_t res_reg, res_next;

    logic [32:0] cr, ci;
    logic        dz;

    always_comb
    begin
        en[LAST] = !v_reg[LAST] || out_ready;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next[0] = en[0] ? in_valid : v_reg[0];
        for (int i = 1; i <= LAST; i++)
        begin
            v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_comb
    begin
        stg0_next.re      = load_lane(din.n_re, din.neg_re, din.d);
        stg0_next.im      = load_lane(din.n_im, din.neg_im, din.d);
        stg0_next.d       = din.d;
        stg0_next.beyond  = din.beyond;
        stg0_next.outcome = din.outcome;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            stg_reg[0] <= stg0_next;
        end
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                stg_reg[k].re      <= step_lane(stg_reg[k-1].re, stg_reg[k-1].d);
                stg_reg[k].im      <= step_lane(stg_reg[k-1].im, stg_reg[k-1].d);
                stg_reg[k].d       <= stg_reg[k-1].d;
                stg_reg[k].beyond  <= stg_reg[k-1].beyond;
                stg_reg[k].outcome <= stg_reg[k-1].outcome;
            end
        end
    end

    always_comb
    begin
        dz = stg_reg[QB].d == '0;
        cr = clip_lane(stg_reg[QB].re, dz);
        ci = clip_lane(stg_reg[QB].im, dz);
        res_next.outcome = stg_reg[QB].outcome;
        if (stg_reg[QB].beyond)
        begin
            res_next.out_real  = '0;
            res_next.out_imag  = '0;
            res_next.saturated = 1'b0;
        end
        else
        begin
            res_next.out_real  = cr[31:0];
            res_next.out_imag  = ci[31:0];
            res_next.saturated = cr[32] | ci[32];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[LAST])
        begin
            res_reg <= res_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[LAST];
    assign dout      = res_reg;

endmodule

// ===== rtl/fpd_checker.sv =====
// Port-level checker for the deconvolution block and its bind to the top level.
module fpd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               pix_ready,
    input logic               res_valid,
    input logic               res_ready,
    input logic signed [31:0] res_real,
    input logic signed [31:0] res_imag,
    input logic [1:0]         res_outcome,
    input logic               res_sat
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result request dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_real) && $stable(res_imag)
                                    && $stable(res_outcome) && $stable(res_sat))
        else $error("stalled result changed");

    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_outcome == 2'(fpd_pkg::OUT_ZERO)
        |-> res_real == 32'sd0 && res_imag == 32'sd0 && !res_sat)
        else $error("cutoff result not zero");

    a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_ready |-> res_valid && !res_ready)
        else $error("pixel channel blocked without output stall");

endmodule

bind fourier_psf_deconvolve_pixel fpd_checker u_fpd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pix_ready   (pixel.ready),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_real    (result.out_real),
    .res_imag    (result.out_imag),
    .res_outcome (result.outcome),
    .res_sat     (result.saturated)
);

// ===== tb/fourier_psf_deconvolve_pixel_tb.sv =====
// Self-checking testbench for the Fourier PSF deconvolution pixel pipeline.
module fourier_psf_deconvolve_pixel_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 50;
    localparam int HOLD_CYCLES    = 300;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [fpd_pkg::ADDR_W-1:0] paddr;
    logic [fpd_pkg::DATA_W-1:0] pwdata;
    logic [fpd_pkg::DATA_W-1:0] prdata;
    logic        pready;

    fpd_pixel_if  pix ();
    fpd_result_if res ();

    fourier_psf_deconvolve_pixel dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pixel   (pix),
        .result  (res)
    );

    // configuration copy used for prediction
    logic [10:0] grid_rows_q;
    logic [31:0] kx_step_q;
    logic [31:0] ky_step_q;
    logic [39:0] cutoff_q;
    logic [30:0] floor_q;

    fpd_pkg::res_t expected_results[$];
    int   mismatches;
    bit   idle_on;
    bit   hold_req;
    int   quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // 32-bit clipped quotient; bit 32 flags saturation
    function automatic logic [32:0] clip_quotient(bit neg, logic [127:0] mag, logic [63:0] d);
        logic [127:0] q;
        if (d == 64'd0)
        begin
            if (mag == 128'd0)
                return {1'b1, 32'd0};
            return neg ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
        end
        q = mag / {64'd0, d};
        if (!neg)
            return (q > 128'h7FFF_FFFF) ? {1'b1, 32'h7FFF_FFFF} : {1'b0, q[31:0]};
        if (q > 128'h8000_0000)
            return {1'b1, 32'h8000_0000};
        return {1'b0, 32'(-q[31:0])};
    endfunction

    function automatic fpd_pkg::res_t deconvolve(fpd_pkg::pix_t p);
        logic signed [127:0] kyi;
        logic signed [127:0] dr, di, pr, pi, sr, si;
        logic [127:0] kymag, kx, ky, r2, pm2, fl2;
        logic [32:0]  qr, qi;
        fpd_pkg::res_t e;
        dr = p.data_real;
        di = p.data_imag;
        pr = p.psf_real;
        pi = p.psf_imag;
        if ({1'b0, p.row_index} < (grid_rows_q >> 1))
            kyi = $signed({118'd0, p.row_index});
        else
            kyi = $signed({118'd0, p.row_index}) - $signed({117'd0, grid_rows_q});
        kymag = (kyi < 0) ? -kyi : kyi;
        kx = {118'd0, p.col_index} * {96'd0, kx_step_q};
        ky = kymag * {96'd0, ky_step_q};
        r2 = kx * kx + ky * ky;
        e.out_real = '0;
        e.out_imag = '0;
        e.outcome = fpd_pkg::OUT_ZERO;
        e.saturated = 1'b0;
        if (r2 > {64'd0, cutoff_q, 24'd0})
            return e;
        pm2 = pr * pr + pi * pi;
        fl2 = {97'd0, floor_q} * {97'd0, floor_q};
        if (pm2 < fl2)
        begin
            qr = clip_quotient(dr < 0, ((dr < 0) ? -dr : dr) << 16, {33'd0, floor_q});
            qi = clip_quotient(di < 0, ((di < 0) ? -di : di) << 16, {33'd0, floor_q});
            e.outcome = fpd_pkg::OUT_FLOOR;
        end
        else
        begin
            sr = dr * pr + di * pi;
            si = di * pr - dr * pi;
            qr = clip_quotient(sr < 0, ((sr < 0) ? -sr : sr) << 16, pm2[63:0]);
            qi = clip_quotient(si < 0, ((si < 0) ? -si : si) << 16, pm2[63:0]);
            e.outcome = fpd_pkg::OUT_PSF;
        end
        e.out_real = qr[31:0];
        e.out_imag = qi[31:0];
        e.saturated = qr[32] | qi[32];
        return e;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 3'b000};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            fpd_pkg::REG_GRID_ROWS:
                grid_rows_q = (value[10:0] > 11'd1024) ? 11'd1024 : value[10:0];
            fpd_pkg::REG_KX_STEP:   kx_step_q = value[31:0];
            fpd_pkg::REG_KY_STEP:   ky_step_q = value[31:0];
            fpd_pkg::REG_CUTOFF:    cutoff_q = value[39:0];
            fpd_pkg::REG_FLOOR:     floor_q = value[30:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [10:0] rows, logic [31:0] kx, logic [31:0] ky,
                              logic [39:0] cut, logic [30:0] fl);
        write_reg(fpd_pkg::REG_GRID_ROWS, 64'(rows));
        write_reg(fpd_pkg::REG_KX_STEP, 64'(kx));
        write_reg(fpd_pkg::REG_KY_STEP, 64'(ky));
        write_reg(fpd_pkg::REG_CUTOFF, 64'(cut));
        write_reg(fpd_pkg::REG_FLOOR, 64'(fl));
    endtask

    task automatic send_pixel(fpd_pkg::pix_t p);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            pix.valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        pix.valid = 1'b1;
        pix.row_index = p.row_index;
        pix.col_index = p.col_index;
        pix.data_real = p.data_real;
        pix.data_imag = p.data_imag;
        pix.psf_real = p.psf_real;
        pix.psf_imag = p.psf_imag;
        do
            @(posedge clk);
        while (!pix.ready);
        expected_results.push_back(deconvolve(p));
        @(negedge clk);
    endtask

    task automatic drain;
        pix.valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic fpd_pkg::pix_t make_pixel(int r, int c, logic [31:0] d_re,
                                                 logic [31:0] d_im, logic [31:0] p_re,
                                                 logic [31:0] p_im);
        fpd_pkg::pix_t p;
        p.row_index = 10'(r);
        p.col_index = 10'(c);
        p.data_real = d_re;
        p.data_imag = d_im;
        p.psf_real = p_re;
        p.psf_imag = p_im;
        return p;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'(int'($urandom_range(0, 8)) - 4);
            3: return 32'(int'($urandom_range(0, 2 ** 18)) - 2 ** 17);
            default: return $urandom;
        endcase
    endfunction

    // psf scaled against the floor so both division paths show up
    function automatic logic [31:0] rand_psf();
        int span;
        span = (floor_q > 31'd1000000) ? 1000000 : int'(floor_q);
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'(int'($urandom_range(0, 2 * span)) - span);
            2: return 32'(int'($urandom_range(0, 4 * span)) - 2 * span);
            default: return rand_value();
        endcase
    endfunction

    task automatic send_random(int count);
        repeat (count)
            send_pixel(make_pixel($urandom_range(0, 1023), $urandom_range(0, 512),
                                  rand_value(), rand_value(), rand_psf(), rand_psf()));
    endtask

    task automatic test_extremes;
        set_config(fpd_pkg::GRID_ROWS_RST, fpd_pkg::STEP_RST, fpd_pkg::STEP_RST,
                   40'(25) << 24, fpd_pkg::FLOOR_RST);
        send_pixel(make_pixel(4, 3, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0));
        send_pixel(make_pixel(5, 3, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0));
        send_pixel(make_pixel(60, 3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0));
        send_pixel(make_pixel(0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_8000, 32'h0));
        send_pixel(make_pixel(32, 0, 32'h1234_5678, 32'hFEDC_BA98, 32'h0002_0000, 32'h1));
        send_pixel(make_pixel(0, 5, 32'h1, 32'h1, 32'h0, 32'h0));
        drain();
        set_config(11'd1024, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 31'd1);
        send_pixel(make_pixel(1023, 512, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1, 32'h0));
        send_pixel(make_pixel(0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h8000_0000));
        send_pixel(make_pixel(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0));
        send_pixel(make_pixel(0, 0, 32'h8000_0000, 32'h0, 32'h0, 32'hFFFF_FFFF));
        send_pixel(make_pixel(0, 0, 32'h0, 32'h0, 32'h0, 32'h0));
        send_pixel(make_pixel(0, 1, 32'h1, 32'h2, 32'h3, 32'h4));
        drain();
        set_config(11'd2, 32'd0, 32'd0, 40'd0, 31'h7FFF_FFFF);
        send_pixel(make_pixel(1023, 512, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                              32'h7FFF_FFFF));
        send_pixel(make_pixel(1, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0));
        send_pixel(make_pixel(512, 0, 32'h0001_0000, 32'h0, 32'h8000_0000, 32'h0));
        drain();
        set_config(11'd7, fpd_pkg::STEP_RST, fpd_pkg::STEP_RST, fpd_pkg::CUTOFF_RST,
                   fpd_pkg::FLOOR_RST);
        send_pixel(make_pixel(3, 0, 32'h0003_0000, 32'h0, 32'h0002_0000, 32'h0));
        send_pixel(make_pixel(4, 0, 32'h0003_0000, 32'h0, 32'h0, 32'h0002_0000));
        send_pixel(make_pixel(1000, 2, 32'hFFFF_0000, 32'h0001_0000, 32'h0, 32'h0));
        drain();
        set_config(11'd0, fpd_pkg::STEP_RST, fpd_pkg::STEP_RST, fpd_pkg::CUTOFF_RST,
                   fpd_pkg::FLOOR_RST);
        send_pixel(make_pixel(0, 1, 32'h0003_0000, 32'h0, 32'h0002_0000, 32'h0));
        send_pixel(make_pixel(513, 0, 32'h0003_0000, 32'h0, 32'h0002_0000, 32'h0));
        drain();
    endtask

    task automatic test_random_config(int count);
        set_config(11'($urandom_range(0, 1024)), $urandom_range(2 ** 20, 2 ** 26),
                   $urandom_range(2 ** 20, 2 ** 26),
                   {16'($urandom_range(0, 65535)), 24'($urandom)},
                   31'($urandom_range(1, 2 ** 20)));
        send_random(count);
        drain();
    endtask

    task automatic test_backpressure;
        set_config(11'd64, fpd_pkg::STEP_RST, fpd_pkg::STEP_RST, {16'd4000, 24'd0},
                   31'h0002_0000);
        hold_req = 1'b1;
        send_random(120);
        drain();
    endtask

    task automatic test_full_range;
        set_config(11'd1024, $urandom, $urandom, {$urandom, 8'($urandom)},
                   31'($urandom_range(1, 32'h7FFF_FFFF)));
        send_random(80);
        drain();
    endtask

    // receiver: random stall bursts and one long hold-off
    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                res.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                res.ready = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            res.ready = rst_n;
        end
    end

    always @(posedge clk)
    begin
        fpd_pkg::res_t e;
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result re=%h im=%h", res.out_real, res.out_imag);
            end
            else
            begin
                e = expected_results.pop_front();
                if (res.out_real !== e.out_real || res.out_imag !== e.out_imag ||
                    res.outcome !== e.outcome || res.saturated !== e.saturated)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch exp re=%h im=%h oc=%0d sat=%b ",
                                  "got re=%h im=%h oc=%0d sat=%b"},
                                 e.out_real, e.out_imag, e.outcome, e.saturated,
                                 res.out_real, res.out_imag, res.outcome, res.saturated);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((pix.valid && pix.ready) || (res.valid && res.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[fourier_psf_deconvolve_pixel] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pix.valid = 1'b0;
        pix.row_index = '0;
        pix.col_index = '0;
        pix.data_real = '0;
        pix.data_imag = '0;
        pix.psf_real = '0;
        pix.psf_imag = '0;
        mismatches = 0;
        quiet_cycles = 0;
        idle_on = 1'b1;
        hold_req = 1'b0;
        grid_rows_q = fpd_pkg::GRID_ROWS_RST;
        kx_step_q = fpd_pkg::STEP_RST;
        ky_step_q = fpd_pkg::STEP_RST;
        cutoff_q = fpd_pkg::CUTOFF_RST;
        floor_q = fpd_pkg::FLOOR_RST;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        send_random(20);
        drain();
        test_extremes();
        test_backpressure();
        repeat (4) test_random_config(110);
        test_full_range();
        idle_on = 1'b0;
        test_random_config(140);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("[fourier_psf_deconvolve_pixel] OK");
        else
            $display("[fourier_psf_deconvolve_pixel] ERROR");
        $finish;
    end
endmodule
